/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; define ASSERT_OFF to drop.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check on every edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define ASSERT_ALW(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif
`endif

/* hw/rtl/ill_pkg.sv */
// ---------------------------------------------------------------------------
// ill_pkg
// Command and status codes, field widths and link store control.
// ---------------------------------------------------------------------------
package ill_pkg;

    localparam int POS_W       = 9;
    localparam int IN_WORD_W   = 32;
    localparam int OUT_WORD_W  = 32;
    localparam int OUT_COUNT_W = 9;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic wr_en;
        logic clear;
    } t_lk_ctl;

endpackage

/* hw/rtl/ill_cmd_if.sv */
// ---------------------------------------------------------------------------
// ill_cmd_if
// Command channel: valid/ready with opcode, position and data word.
// ---------------------------------------------------------------------------
interface ill_cmd_if;
    import ill_pkg::*;

    logic               valid;
    logic               ready;
    t_op                cmd;
    logic [POS_W-1:0]   position;
    logic [IN_WORD_W-1:0] word_in;

    modport source (output valid, cmd, position, word_in, input ready);
    modport sink   (input valid, cmd, position, word_in, output ready);
endinterface

/* hw/rtl/ill_res_if.sv */
// ---------------------------------------------------------------------------
// ill_res_if
// Result channel: valid/ready with status, word, count and empty flag.
// ---------------------------------------------------------------------------
interface ill_res_if;
    import ill_pkg::*;

    logic                   valid;
    logic                   ready;
    t_status                status;
    logic [OUT_WORD_W-1:0]  word_out;
    logic [OUT_COUNT_W-1:0] count;
    logic                   empty_res;

    modport source (output valid, status, word_out, count, empty_res, input ready);
    modport sink   (input valid, status, word_out, count, empty_res, output ready);
endinterface

/* hw/rtl/indexed_linked_list_engine.sv */
// ---------------------------------------------------------------------------
// indexed_linked_list_engine
// Fixed-capacity singly linked list with positional insert, remove, read
// and clear, built on a word memory and a next-link memory.
// ---------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------
//  i_cmd    | in  | valid / ready | cmd, position, word_in
//  o_res    | out | valid / ready | status, word_out, count, empty_res
//
//  Commands: one at a time. Errors and clear go straight to the result. An
//  insert first pops a free node; all other work, but for insert at the head,
//  walks the links to the position, reading one node a cycle through the
//  single read port of the link memory.
//  Reset: synchronous, active low; the list is usable on the next cycle,
//  with no clearing pass (a high-water mark stands in for the free chain).
//  Stalls: a held result sits in the output register while the next command
//  is taken; that command waits in its final state until the result leaves.
//
`include "assert_macros.svh"

module indexed_linked_list_engine #(
    parameter int CAPACITY   = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ill_cmd_if.sink   i_cmd,
    ill_res_if.source o_res
);
    import ill_pkg::*;

    localparam int SLW  = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    // bits beyond the input width are never set, so keep only what can be
    localparam int SW   = (WORD_WIDTH < IN_WORD_W) ? WORD_WIDTH : IN_WORD_W;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FREE  = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_LINK1 = 7'b0001000,
        S_LINK2 = 7'b0010000,
        S_LINK3 = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // control state
    t_state         r_state, n_state;
    logic [SLW-1:0] r_head, n_head;
    logic [SLW-1:0] r_free, n_free;
    logic [CW-1:0]  r_count, n_count;
    logic           r_out_valid;

    // command context
    t_op            r_op, n_op;
    logic           r_pos_zero, n_pos_zero;
    logic [SW-1:0]  r_word, n_word;
    logic [SLW-1:0] r_cur, n_cur;      // walk cursor, then the node before the position (the node itself on a read)
    logic [SLW-1:0] r_sel, n_sel;      // node being linked in or unlinked
    logic [POS_W-1:0] r_left, n_left;  // link reads still to issue
    logic           r_pend, n_pend;    // a link read is in flight for the cursor
    t_status        r_status, n_status;
    logic [SW-1:0]  r_wout, n_wout;

    // output register
    t_status                r_out_status;
    logic [OUT_WORD_W-1:0]  r_out_word;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic                   r_out_empty;

    // word memory
    logic [SW-1:0]  r_wmem [CAPACITY];
    logic [SW-1:0]  r_wd_q;
    logic [SLW-1:0] wd_rd_addr;
    logic           wd_we;

    // link store
    t_lk_ctl        lk_ctl;
    logic [SLW-1:0] lk_rd_addr;
    logic [SLW-1:0] lk_wr_addr;
    logic [SLW-1:0] lk_wr_data;
    logic [SLW-1:0] lk_rd;

    logic           in_ready;
    logic           in_fire;
    logic           out_load;
    logic [SLW-1:0] walk_cur;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;

    ill_link_store #(
        .CAPACITY (CAPACITY)
    ) u_links (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (lk_ctl),
        .i_rd_addr (lk_rd_addr),
        .i_wr_addr (lk_wr_addr),
        .i_wr_data (lk_wr_data),
        .o_rd_data (lk_rd)
    );

    assign in_ready = (r_state == S_IDLE);
    assign in_fire  = i_cmd.valid && in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // cursor follows the link data straight back into the read address
    assign walk_cur = r_pend ? lk_rd : r_cur;

    assign pos_x = CMPW'(i_cmd.position);
    assign cnt_x = CMPW'(r_count);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_free     = r_free;
        n_count    = r_count;
        n_op       = r_op;
        n_pos_zero = r_pos_zero;
        n_word     = r_word;
        n_cur      = r_cur;
        n_sel      = r_sel;
        n_left     = r_left;
        n_pend     = r_pend;
        n_status   = r_status;
        n_wout     = r_wout;

        lk_ctl     = '0;
        lk_rd_addr = r_free;
        lk_wr_addr = r_sel;
        lk_wr_data = r_head;
        wd_rd_addr = r_cur;
        wd_we      = 1'b0;

        case (r_state)
            S_IDLE: begin
                // the idle read of the free head feeds S_FREE on an insert
                if (in_fire) begin
                    n_op       = i_cmd.cmd;
                    n_pos_zero = (i_cmd.position == '0);
                    n_word     = SW'(i_cmd.word_in);
                    n_sel      = r_free;
                    n_cur      = r_head;
                    n_pend     = 1'b0;
                    n_wout     = '0;
                    n_status   = ST_OK;
                    n_left     = (i_cmd.position == '0) ? '0
                                 : POS_W'(i_cmd.position - POS_W'(1));
                    case (i_cmd.cmd)
                        OP_INSERT: begin
                            if (pos_x > cnt_x) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else if (r_count >= CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state  = S_FREE;
                            end
                        end
                        OP_REMOVE: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_state  = S_WALK;
                            end
                        end
                        OP_READ: begin
                            n_left = i_cmd.position;
                            if (pos_x >= cnt_x) begin
                                n_status = ST_RANGE;
                                n_state  = S_DONE;
                            end else begin
                                n_state  = S_WALK;
                            end
                        end
                        default: begin
                            // clear: empty list, free chain back in reset order
                            n_head       = '0;
                            n_free       = '0;
                            n_count      = '0;
                            lk_ctl.clear = 1'b1;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end

            S_FREE: begin
                // pop the free head, store the word
                n_free = lk_rd;
                wd_we  = 1'b1;
                if (r_pos_zero) begin
                    lk_ctl.wr_en = 1'b1;
                    lk_wr_addr   = r_sel;
                    lk_wr_data   = r_head;
                    n_head       = r_sel;
                    n_count      = CW'(r_count + CW'(1));
                    n_state      = S_DONE;
                end else begin
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                // one link read a cycle; the last read fetches the final node's link
                lk_rd_addr = walk_cur;
                wd_rd_addr = walk_cur;
                n_cur      = walk_cur;
                if (r_left == '0) begin
                    n_state = S_LINK1;
                end else begin
                    n_left = POS_W'(r_left - POS_W'(1));
                    n_pend = 1'b1;
                end
            end

            S_LINK1: begin
                case (r_op)
                    OP_INSERT: begin
                        // new node takes over the successor of the node before it
                        lk_ctl.wr_en = 1'b1;
                        lk_wr_addr   = r_sel;
                        lk_wr_data   = lk_rd;
                        n_state      = S_LINK2;
                    end
                    OP_REMOVE: begin
                        if (r_pos_zero) begin
                            n_head       = lk_rd;
                            n_wout       = r_wd_q;
                            lk_ctl.wr_en = 1'b1;
                            lk_wr_addr   = r_cur;
                            lk_wr_data   = r_free;
                            n_free       = r_cur;
                            n_count      = CW'(r_count - CW'(1));
                            n_state      = S_DONE;
                        end else begin
                            n_sel      = lk_rd;
                            lk_rd_addr = lk_rd;
                            wd_rd_addr = lk_rd;
                            n_state    = S_LINK2;
                        end
                    end
                    OP_READ: begin
                        n_wout  = r_wd_q;
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_LINK2: begin
                lk_ctl.wr_en = 1'b1;
                lk_wr_addr   = r_cur;
                if (r_op == OP_INSERT) begin
                    lk_wr_data = r_sel;
                    n_count    = CW'(r_count + CW'(1));
                    n_state    = S_DONE;
                end else begin
                    // bypass the removed node
                    lk_wr_data = lk_rd;
                    n_wout     = r_wd_q;
                    n_state    = S_LINK3;
                end
            end

            S_LINK3: begin
                // push the removed node onto the free list
                lk_ctl.wr_en = 1'b1;
                lk_wr_addr   = r_sel;
                lk_wr_data   = r_free;
                n_free       = r_sel;
                n_count      = CW'(r_count - CW'(1));
                n_state      = S_DONE;
            end

            S_DONE: begin
                // hold until the output register can take the result
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pos_zero <= n_pos_zero;
        r_word     <= n_word;
        r_cur      <= n_cur;
        r_sel      <= n_sel;
        r_left     <= n_left;
        r_pend     <= n_pend;
        r_status   <= n_status;
        r_wout     <= n_wout;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_word   <= OUT_WORD_W'(r_wout);
            r_out_count  <= OUT_COUNT_W'(r_count);
            r_out_empty  <= (r_count == '0);
        end
    end

    // word memory: written on allocation, read through a registered output
    always_ff @(posedge i_clk) begin
        if (wd_we) begin
            r_wmem[r_sel] <= r_word;
        end
        r_wd_q <= r_wmem[wd_rd_addr];
    end

    assign i_cmd.ready     = in_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.status    = r_out_status;
    assign o_res.word_out  = r_out_word;
    assign o_res.count     = r_out_count;
    assign o_res.empty_res = r_out_empty;

    `ASSERT_RST(a_clear_state, i_clk, i_rst_n, ((in_fire && i_cmd.cmd == OP_CLEAR) |=> (r_count == '0 && r_head == '0 && r_free == '0)), "clear left list state behind")
    `ASSERT_RST(a_count_step, i_clk, i_rst_n, ((r_state != S_IDLE) |=> (r_count == $past(r_count) || r_count == CW'($past(r_count) + CW'(1)) || r_count == CW'($past(r_count) - CW'(1)))), "count moved by more than one")
    `ASSERT_RST(a_done_hold, i_clk, i_rst_n, ((r_state == S_DONE && r_out_valid && !o_res.ready) |=> (r_state == S_DONE && r_out_valid)), "result dropped while output stalled")

endmodule

/* hw/rtl/ill_link_store.sv */
// ---------------------------------------------------------------------------
// ill_link_store
// Next-link memory with a high-water mark: slots at or above it read as the
// reset free chain, so reset and clear need no sweep.
// ---------------------------------------------------------------------------
module ill_link_store #(
    parameter int CAPACITY = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ill_pkg::t_lk_ctl              i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   i_rd_addr,
    input  logic [$clog2(CAPACITY)-1:0]   i_wr_addr,
    input  logic [$clog2(CAPACITY)-1:0]   i_wr_data,
    output logic [$clog2(CAPACITY)-1:0]   o_rd_data
);
    import ill_pkg::*;

    localparam int SLW = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);

    logic [SLW-1:0] r_mem [CAPACITY];
    logic [SLW-1:0] r_q;
    logic [SLW-1:0] r_fresh_val;
    logic           r_fresh;
    logic [CW-1:0]  r_hwm;

    logic [SLW-1:0] chain_val;
    logic           rd_fresh;

    // reset chain: slot i links to i+1, last slot wraps to 0
    assign chain_val = (i_rd_addr == SLW'(CAPACITY - 1)) ? '0
                                                         : SLW'(i_rd_addr + SLW'(1));
    assign rd_fresh  = (CW'(i_rd_addr) >= r_hwm);

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q         <= r_mem[i_rd_addr];
        r_fresh     <= rd_fresh;
        r_fresh_val <= chain_val;
    end

    // slots are first written in allocation order, so the mark only steps by one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hwm <= '0;
        end else if (i_ctl.clear) begin
            r_hwm <= '0;
        end else if (i_ctl.wr_en && (CW'(i_wr_addr) == r_hwm)) begin
            r_hwm <= CW'(r_hwm + CW'(1));
        end
    end

    assign o_rd_data = r_fresh ? r_fresh_val : r_q;

endmodule

/* tb/tb_indexed_linked_list_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_indexed_linked_list_engine
// Self-checking bench for the linked-list engine. Keeps a plain word queue as
// the list and works out each result when its command transfer happens. It
// drives directed corner commands first and then random command mixes under
// changing back-pressure.
// ---------------------------------------------------------------------------
module tb_indexed_linked_list_engine;
    import ill_pkg::*;

    localparam int CAPACITY    = 256;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 300;     // worst walk plus a margin

    typedef struct {
        t_status               status;
        logic [OUT_WORD_W-1:0]  word;
        logic [OUT_COUNT_W-1:0] count;
        logic                   empty;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    ill_cmd_if cmd_if ();
    ill_res_if res_if ();

    indexed_linked_list_engine #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (32)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // List contents in list order; entry 0 is the head.
    logic [IN_WORD_W-1:0] list_words[$];
    // Results owed by the engine, oldest first.
    t_list_result         owed_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count = 0;
    int cycle_count = 0;

    // ------------------------------------------------------------------
    // Clock, cycle limit and result-side stall pattern
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_indexed_linked_list_engine NOT OK");
            $finish;
        end
    end

    // Drop ready at random; with recv_idle_pct at zero it stays high.
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Predictor: apply one command to the word queue and form its result.
    // Failed commands leave the list alone and return a zero word.
    // ------------------------------------------------------------------
    function automatic t_list_result apply_list_cmd(t_op op, logic [POS_W-1:0] pos,
                                                    logic [IN_WORD_W-1:0] word);
        t_list_result r;
        int p;
        int sz;
        p        = int'(pos);
        sz       = list_words.size();
        r.status = ST_OK;
        r.word   = '0;
        case (op)
            OP_INSERT: begin
                // position is checked before the store is tested for full
                if (p > sz) r.status = ST_RANGE;
                else if (sz >= CAPACITY) r.status = ST_FULL;
                else list_words.insert(p, word);
            end
            OP_REMOVE: begin
                if (p >= sz) begin
                    r.status = ST_RANGE;
                end else begin
                    r.word = list_words[p];
                    list_words.delete(p);
                end
            end
            OP_READ: begin
                if (p >= sz) r.status = ST_RANGE;
                else r.word = list_words[p];
            end
            default: begin
                list_words.delete();
            end
        endcase
        r.count = OUT_COUNT_W'(list_words.size());
        r.empty = (list_words.size() == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every result transfer pops the oldest owed result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_result exp;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (owed_results.size() == 0) begin
                error_count++;
                $display("%0t: result with none owed: status %0d word %h count %0d empty %0b",
                         $time, res_if.status, res_if.word_out, res_if.count,
                         res_if.empty_res);
            end else begin
                exp = owed_results.pop_front();
                if (res_if.status !== exp.status || res_if.word_out !== exp.word ||
                    res_if.count !== exp.count || res_if.empty_res !== exp.empty) begin
                    error_count++;
                    $display("%0t: expected status %0d word %h count %0d empty %0b, %s",
                             $time, exp.status, exp.word, exp.count, exp.empty, "got");
                    $display("%0t:      actual status %0d word %h count %0d empty %0b",
                             $time, res_if.status, res_if.word_out, res_if.count,
                             res_if.empty_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Command driver. Valid stays high after a transfer so back-to-back
    // commands never lower and raise it in one step; idle gaps lower it.
    // ------------------------------------------------------------------
    task automatic send_cmd(t_op op, logic [POS_W-1:0] pos, logic [IN_WORD_W-1:0] word);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.cmd      <= op;
        cmd_if.position <= pos;
        cmd_if.word_in  <= word;
        do @(posedge i_clk); while (!cmd_if.ready);
        owed_results.push_back(apply_list_cmd(op, pos, word));
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every positional command against an empty list is out of range,
    // including insert past the end and positions with the top bit set.
    task automatic test_empty_list();
        send_cmd(OP_CLEAR,  9'd0,   32'h0);
        send_cmd(OP_READ,   9'd0,   32'h0);
        send_cmd(OP_REMOVE, 9'd0,   32'h0);
        send_cmd(OP_INSERT, 9'd1,   32'h1234_5678);
        send_cmd(OP_INSERT, 9'd511, 32'hFFFF_FFFF);
        send_cmd(OP_READ,   9'd256, 32'h0);
    endtask

    // Insert at head, tail and middle; remove at head, middle and tail.
    task automatic test_positional_ops();
        send_cmd(OP_INSERT, 9'd0, 32'hFFFF_FFFF);  // empty list takes position 0
        send_cmd(OP_INSERT, 9'd1, 32'h0000_0000);  // append at the end
        send_cmd(OP_INSERT, 9'd1, 32'hA5A5_5A5A);  // middle
        send_cmd(OP_INSERT, 9'd0, 32'h8000_0001);  // new head
        send_cmd(OP_READ,   9'd0, 32'h0);
        send_cmd(OP_READ,   9'd1, 32'h0);
        send_cmd(OP_READ,   9'd2, 32'h0);
        send_cmd(OP_READ,   9'd3, 32'h0);
        send_cmd(OP_INSERT, 9'd4, 32'h7FFF_FFFE);
        send_cmd(OP_READ,   9'd4, 32'h0);
        send_cmd(OP_REMOVE, 9'd2, 32'h0);          // walk stops one short
        send_cmd(OP_REMOVE, 9'd3, 32'h0);          // tail
        send_cmd(OP_REMOVE, 9'd0, 32'h0);          // head
        send_cmd(OP_READ,   9'd5, 32'h0);
        send_cmd(OP_REMOVE, 9'd2, 32'h0);          // one past the end
        send_cmd(OP_CLEAR,  9'h1FF, 32'hFFFF_FFFF);
        send_cmd(OP_READ,   9'd0, 32'h0);
    endtask

    // Fill the store, then probe full against out of range, refill a slot
    // and check that clear rebuilds a usable free chain.
    task automatic test_full_store();
        int n;
        send_cmd(OP_CLEAR, 9'd0, 32'h0);
        for (n = 0; n < CAPACITY; n++) begin
            send_cmd(OP_INSERT, POS_W'($urandom_range(list_words.size(), 0)), $urandom());
        end
        send_cmd(OP_INSERT, 9'd256, 32'hDEAD_BEEF);  // full
        send_cmd(OP_INSERT, 9'd257, 32'hDEAD_BEEF);  // range wins over full
        send_cmd(OP_INSERT, 9'd0,   32'hDEAD_BEEF);  // full
        send_cmd(OP_READ,   9'd255, 32'h0);
        send_cmd(OP_READ,   9'd256, 32'h0);
        send_cmd(OP_REMOVE, 9'd128, 32'h0);
        send_cmd(OP_INSERT, 9'd255, 32'h0BAD_F00D);  // reuse the freed node
        send_cmd(OP_REMOVE, 9'd255, 32'h0);
        send_cmd(OP_REMOVE, 9'd0,   32'h0);
        send_cmd(OP_CLEAR,  9'd0,   32'h0);
        send_cmd(OP_INSERT, 9'd0,   32'hC0DE_CAFE);
        send_cmd(OP_READ,   9'd0,   32'h0);
    endtask

    // Mostly legal positions on a list that drifts toward size_goal,
    // with a share of out-of-range and end-of-list positions.
    task automatic test_random_mix(int n_items, int size_goal, int clear_pct);
        int n;
        int sz;
        int roll;
        int ins_w;
        t_op op;
        logic [POS_W-1:0] pos;
        for (n = 0; n < n_items; n++) begin
            sz    = list_words.size();
            roll  = $urandom_range(99);
            ins_w = (sz < size_goal) ? 50 : 30;
            if (roll < clear_pct) op = OP_CLEAR;
            else if (roll < clear_pct + ins_w) op = OP_INSERT;
            else if (roll < clear_pct + ins_w + 25) op = OP_REMOVE;
            else op = OP_READ;

            roll = $urandom_range(99);
            if (op == OP_CLEAR) begin
                pos = POS_W'($urandom());
            end else if (op == OP_INSERT) begin
                if (roll < 10) pos = POS_W'($urandom_range(511, sz + 1));
                else if (roll < 20) pos = POS_W'(sz);
                else pos = POS_W'($urandom_range(sz, 0));
            end else begin
                if (sz == 0 || roll < 10) pos = POS_W'($urandom_range(511, sz));
                else if (roll < 20) pos = POS_W'(sz - 1);
                else pos = POS_W'($urandom_range(sz - 1, 0));
            end
            send_cmd(op, pos, $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        cmd_if.valid    <= 1'b0;
        cmd_if.cmd      <= OP_READ;
        cmd_if.position <= '0;
        cmd_if.word_in  <= '0;
        send_idle_pct   = 11;
        recv_idle_pct   = 69;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_positional_ops();
        test_full_store();
        test_random_mix(540, 30, 3);
        drain_results();

        send_idle_pct = 69;
        recv_idle_pct = 11;
        test_random_mix(540, 120, 1);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(540, 260, 0);
        drain_results();

        // Catch any stray result after the last one owed.
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_indexed_linked_list_engine OK");
        end else begin
            $display("tb_indexed_linked_list_engine NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/ill_pkg.sv
hw/rtl/ill_cmd_if.sv
hw/rtl/ill_res_if.sv
hw/rtl/ill_link_store.sv
hw/rtl/indexed_linked_list_engine.sv
tb/tb_indexed_linked_list_engine.sv
